FILE: src/dma_descriptor_splitter_assert.svh
// assertion macros shared by the descriptor splitter checkers
`ifndef DMA_DESCRIPTOR_SPLITTER_ASSERT_SVH
`define DMA_DESCRIPTOR_SPLITTER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define DDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define DDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/dds_pkg.sv
// types and constants of the dma descriptor splitter
package dds_pkg;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 32;
    localparam int BLK_W       = 16;
    localparam int REGION_W    = 28;
    localparam int MAX_NODES_DEF = 64;

    // a remaining length below this is taken whole as the nominal chunk
    localparam logic [LEN_W-1:0] SHORT_LIMIT = 32'h0001_0000;
    // chunk size for long remainders
    localparam logic [BLK_W-1:0] LONG_CHUNK  = 16'hfffc;
    // size of one 256 MiB region, one past the region mask
    localparam logic [REGION_W:0] REGION_SIZE = {1'b1, {REGION_W{1'b0}}};

    // per-node result of the chunk unit
    typedef struct packed {
        logic [BLK_W-1:0]  chunk;
        logic [ADDR_W-1:0] addr_next;
        logic [LEN_W-1:0]  bytes_next;
        logic              done;
    } node_calc_t;

endpackage

FILE: src/dds_chunk_unit.sv
// shared chunk unit: sizes one node and advances cursor and remainder
module dds_chunk_unit
    import dds_pkg::*;
(
    input  logic [ADDR_W-1:0] cursor,
    input  logic [LEN_W-1:0]  bytes_left,
    output node_calc_t        calc
);

    logic [BLK_W-1:0]    cand;
    logic [REGION_W:0]   room;
    logic [BLK_W-1:0]    chunk;

    // nominal chunk from the remaining length
    assign cand = (bytes_left < SHORT_LIMIT) ? bytes_left[BLK_W-1:0] : LONG_CHUNK;

    // bytes up to the next 256 MiB boundary, 1 .. region size
    assign room = REGION_SIZE - {1'b0, cursor[REGION_W-1:0]};

    // clip at the boundary; a clipped chunk is below the nominal one so it fits
    assign chunk = ({{(REGION_W+1-BLK_W){1'b0}}, cand} > room) ? room[BLK_W-1:0] : cand;

    always_comb
    begin
        calc.chunk      = chunk;
        calc.addr_next  = cursor + {{(ADDR_W-BLK_W){1'b0}}, chunk};
        calc.bytes_next = bytes_left - {{(LEN_W-BLK_W){1'b0}}, chunk};
        calc.done       = ({{(LEN_W-BLK_W){1'b0}}, chunk} == bytes_left);
    end

endmodule

FILE: src/dds_seq.sv
// sequencer: holds the run state and the output register
module dds_seq
    import dds_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ADDR_W-1:0] in_addr,
    input  logic [LEN_W-1:0]  in_len,
    output logic [ADDR_W-1:0] cursor,
    output logic [LEN_W-1:0]  bytes_left,
    input  node_calc_t        calc,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] out_addr,
    output logic [BLK_W-1:0]  out_len,
    output logic              out_xfer_end,
    output logic              out_last,
    output logic              out_trunc
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_NODES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BLK_W-1:0]  len_reg, len_next;
    logic              xfer_end_reg, xfer_end_next;
    logic              last_reg, last_next;
    logic              trunc_reg, trunc_next;
    logic              advance;
    logic              last_node;

    // a node is produced when running and the output slot is free or draining
    assign advance   = (state_reg == ST_RUN) && (!valid_reg || out_ready);
    assign last_node = (calc.bytes_next == '0) || (count_reg == CNT_LAST);

    // next-state and output register logic
    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        bytes_next    = bytes_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        xfer_end_next = xfer_end_reg;
        last_next     = last_reg;
        trunc_next    = trunc_reg;

        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cursor_next = in_addr;
                    bytes_next  = in_len;
                    count_next  = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    valid_next    = 1'b1;
                    addr_next     = cursor_reg;
                    len_next      = calc.chunk;
                    xfer_end_next = calc.done;
                    last_next     = last_node;
                    trunc_next    = last_node && (calc.bytes_next != '0);
                    cursor_next   = calc.addr_next;
                    bytes_next    = calc.bytes_next;
                    count_next    = count_reg + CNT_ONE;
                    if (last_node)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cursor_reg   <= '0;
            bytes_reg    <= '0;
            count_reg    <= '0;
            valid_reg    <= 1'b0;
            addr_reg     <= '0;
            len_reg      <= '0;
            xfer_end_reg <= 1'b0;
            last_reg     <= 1'b0;
            trunc_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            bytes_reg    <= bytes_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            addr_reg     <= addr_next;
            len_reg      <= len_next;
            xfer_end_reg <= xfer_end_next;
            last_reg     <= last_next;
            trunc_reg    <= trunc_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cursor       = cursor_reg;
    assign bytes_left   = bytes_reg;
    assign out_valid    = valid_reg;
    assign out_addr     = addr_reg;
    assign out_len      = len_reg;
    assign out_xfer_end = xfer_end_reg;
    assign out_last     = last_reg;
    assign out_trunc    = trunc_reg;

endmodule

FILE: src/dma_descriptor_splitter.sv
// Splits a transfer request (start address, byte length) into a run of
// DMA descriptor nodes, one node per cycle while the output is taken.
// A request is loaded into the run state; a run then holds N nodes,
// N being 1 .. MAX_NODES, each set by one pass of the shared chunk unit
// (remaining-length select, 256 MiB boundary clip, address and length
// update). The input is not ready from the cycle after a request is taken
// until the run's last node has been loaded into the output register.
// tlast marks the last node of a run; tuser carries xfer_end and truncated.
module dma_descriptor_splitter
    import dds_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // base_addr[31:0], transfer_length[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // node_addr[31:0], block_len[47:32]
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // xfer_end[0], truncated[1]
);

    logic [ADDR_W-1:0] cursor;
    logic [LEN_W-1:0]  bytes_left;
    node_calc_t        calc;
    logic [ADDR_W-1:0] node_addr;
    logic [BLK_W-1:0]  block_len;
    logic              xfer_end;
    logic              truncated;

    // per-node arithmetic
    dds_chunk_unit u_chunk (
        .cursor     (cursor),
        .bytes_left (bytes_left),
        .calc       (calc)
    );

    // run sequencer and output register
    dds_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_addr      (s_axis_tdata[31:0]),
        .in_len       (s_axis_tdata[63:32]),
        .cursor       (cursor),
        .bytes_left   (bytes_left),
        .calc         (calc),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_addr     (node_addr),
        .out_len      (block_len),
        .out_xfer_end (xfer_end),
        .out_last     (m_axis_tlast),
        .out_trunc    (truncated)
    );

    assign m_axis_tdata = {block_len, node_addr};
    assign m_axis_tuser = {truncated, xfer_end};

endmodule

FILE: src/dds_checker.sv
// port-level checker for the dma descriptor splitter, bound to the top level
`include "dma_descriptor_splitter_assert.svh"

module dds_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    logic in_take;
    logic out_stall;
    logic out_flagged;

    assign in_take     = s_axis_tvalid && s_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_flagged = m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]);

    // a taken request keeps the input closed while its run is produced
    `DDS_ASSERT_NXT(a_busy_after_take, in_take, !s_axis_tready, "input ready right after a take")

    // a stalled node holds its contents
    `DDS_ASSERT_NXT(a_out_hold, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser),
        "stalled node changed")

    // finishing the transfer or hitting the node limit closes the run
    `DDS_ASSERT_IMP(a_flags_end_run, out_flagged, m_axis_tlast,
        "transfer end or truncated without tlast")

    // a node cannot both finish the transfer and be truncated
    `DDS_ASSERT_IMP(a_flags_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]),
        "transfer end and truncated together")

endmodule

bind dma_descriptor_splitter dds_checker u_dds_checker (.*);

FILE: test/dds_node_checker.sv
// checker for the dma descriptor splitter: predicts each run of nodes and compares them
module dds_node_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // base_addr[31:0], transfer_length[63:32]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // node_addr[31:0], block_len[47:32]
    input  logic        m_axis_tlast,   // last_of_run
    input  logic [1:0]  m_axis_tuser,   // xfer_end[0], truncated[1]
    output int          fail_count,
    output int          nodes_pending
);

    localparam int          NODE_LIMIT  = 64;
    localparam logic [31:0] SINGLE_MAX  = 32'h0001_0000;
    localparam logic [31:0] FULL_CHUNK  = 32'h0000_fffc;
    localparam logic [31:0] REGION_MASK = 32'h0fff_ffff;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] len;
        logic        xfer_end;
        logic        last_of_run;
        logic        truncated;
    } node_t;

    node_t pending_nodes[$];

    // walk one request through the chunk rules and queue every node it yields
    function automatic void split_request(input logic [31:0] base, input logic [31:0] total);
        logic [31:0] cursor;
        logic [31:0] left;
        logic [31:0] chunk;
        logic [32:0] region_end;
        int          count;
        node_t       node;
        cursor = base;
        left   = total;
        count  = 0;
        do
        begin
            chunk      = (left < SINGLE_MAX) ? left : FULL_CHUNK;
            region_end = {1'b0, cursor | REGION_MASK} + 33'd1;
            // clip so the block ends at or before the next 256 MiB boundary
            if ({1'b0, cursor} + {1'b0, chunk} > region_end)
                chunk = 32'(region_end - {1'b0, cursor});
            node.addr     = cursor;
            node.len      = chunk[15:0];
            node.xfer_end = (chunk == left);
            cursor = cursor + chunk;
            left   = left - chunk;
            count++;
            node.last_of_run = (left == 0) || (count >= NODE_LIMIT);
            node.truncated   = node.last_of_run && (left != 0);
            pending_nodes.push_back(node);
        end
        while (left != 0 && count < NODE_LIMIT);
    endfunction

    initial
    begin
        fail_count    = 0;
        nodes_pending = 0;
    end

    // compare each accepted node first, then expand each accepted request
    always @(posedge clk)
    begin
        node_t want;
        node_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.addr        = m_axis_tdata[31:0];
                got.len         = m_axis_tdata[47:32];
                got.xfer_end    = m_axis_tuser[0];
                got.last_of_run = m_axis_tlast;
                got.truncated   = m_axis_tuser[1];
                if (pending_nodes.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected node: addr=%h len=%h end=%b last=%b trunc=%b",
                                 got.addr, got.len, got.xfer_end, got.last_of_run,
                                 got.truncated);
                    fail_count++;
                end
                else
                begin
                    want = pending_nodes.pop_front();
                    if (got.addr !== want.addr || got.len !== want.len
                        || got.xfer_end !== want.xfer_end
                        || got.last_of_run !== want.last_of_run
                        || got.truncated !== want.truncated)
                    begin
                        if (fail_count < REPORT_MAX)
                        begin
                            $display("node mismatch: expected addr=%h len=%h end=%b last=%b trunc=%b",
                                     want.addr, want.len, want.xfer_end, want.last_of_run,
                                     want.truncated);
                            $display("               actual   addr=%h len=%h end=%b last=%b trunc=%b",
                                     got.addr, got.len, got.xfer_end, got.last_of_run,
                                     got.truncated);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                split_request(s_axis_tdata[31:0], s_axis_tdata[63:32]);
            nodes_pending = pending_nodes.size();
        end
    end

endmodule

FILE: test/tb_dma_descriptor_splitter.sv
// testbench top for the dma descriptor splitter: stimulus, flow control and verdict
module tb_dma_descriptor_splitter;

    localparam int RANDOM_ITEMS = 248;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          nodes_pending;
    bit          send_idle;
    bit          recv_idle;

    dma_descriptor_splitter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    dds_node_checker u_node_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .nodes_pending (nodes_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // node sink with random back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = recv_idle ? ($urandom_range(0, 99) >= 31) : 1'b1;
        end
    end

    // present one request, with optional random gaps, and hold it until taken
    task automatic send_request(input logic [31:0] addr, input logic [31:0] len);
        while (send_idle && $urandom_range(0, 99) < 31)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom};
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {len, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        logic [31:0] addr;
        logic [31:0] len;
        int          phase;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero length, single short chunks
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hffff_ffff, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0001);
        send_request(32'h0000_1000, 32'h0000_ffff);
        // length at and above the single chunk limit
        send_request(32'h0000_2000, 32'h0001_0000);
        send_request(32'h1234_5678, 32'h0001_fff8);
        // chunk ending exactly on a 256 MiB boundary, and one crossing it
        send_request(32'h0fff_fff0, 32'h0000_0010);
        send_request(32'h0fff_fff0, 32'h0000_0020);
        send_request(32'h0fff_0000, 32'h0002_0000);
        send_request(32'h0fff_ffff, 32'h0000_ffff);
        // address wrap at the top of the address space
        send_request(32'hffff_fff0, 32'h0000_0040);
        send_request(32'hffff_0000, 32'h0003_0000);
        send_request(32'hffff_ffff, 32'h0000_0001);
        send_request(32'hffff_ffff, 32'hffff_ffff);
        // node limit: exactly full, one byte over, far over
        send_request(32'h4000_0000, 32'h003f_ff00);
        send_request(32'h4000_0000, 32'h003f_ff01);
        send_request(32'h0000_0000, 32'hffff_ffff);
        send_request(32'h0fe0_0000, 32'h0040_0000);
        // alternating bit patterns
        send_request(32'haaaa_aaaa, 32'h5555_5555);
        send_request(32'h5555_5555, 32'haaaa_aaaa);
        send_request(32'haaaa_aaa8, 32'h0000_5555);
        send_request(32'h5555_5554, 32'h0000_aaaa);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // idling pattern changes every stretch; the second one has none at all
            phase = i / 54;
            send_idle = (phase == 0) || (phase == 2) || (phase == 4);
            recv_idle = (phase == 0) || (phase == 3) || (phase == 4);
            case ($urandom_range(0, 3))
                0: addr = $urandom;
                1: addr = {4'($urandom_range(0, 15)), 28'h0} - $urandom_range(0, 32'h40000);
                2: addr = {4'($urandom_range(0, 15)), 28'h0};
                default: addr = $urandom & 32'hffff_fffc;
            endcase
            case ($urandom_range(0, 9)) inside
                [0:2]: len = $urandom_range(0, 32'h20000);
                [3:5]: len = $urandom_range(0, 32'h200000);
                6: len = 32'h003f_ff00 - 32'd4 + $urandom_range(0, 8);
                7: len = $urandom;
                8: len = $urandom_range(0, 4);
                default: len = $urandom_range(0, 32'h400000);
            endcase
            send_request(addr, len);
        end
        s_axis_tvalid = 1'b0;
        send_idle     = 1'b0;
        recv_idle     = 1'b1;

        // drain, then watch a little longer for stray nodes
        while (nodes_pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/dds_pkg.sv
src/dds_chunk_unit.sv
src/dds_seq.sv
src/dma_descriptor_splitter.sv
src/dds_checker.sv
test/dds_node_checker.sv
test/tb_dma_descriptor_splitter.sv
